[rtl/rdw_pkg.sv]
package rdw_pkg;

  // Fixed field widths of the block.
  localparam int VecW    = 16;
  localparam int ColorW  = 16;
  localparam int WeightW = 24;
  localparam int FracW   = VecW - 2;
  localparam int RatioW  = 16;
  localparam int ArW     = 21;
  localparam int SqrtW   = 15;
  localparam int DenW    = 18;
  localparam int NumW    = FracW + 16;
  localparam int CfgIdxW = 3;

  // Exit cosine threshold, 0.01 in Q1.14.
  localparam int CosThr = ((1 << FracW) + 50) / 100;

  typedef enum logic [CfgIdxW-1:0] {
    RegIndexRatio   = 3'd0,
    RegInverseIndex = 3'd1,
    RegTransRed     = 3'd2,
    RegTransGreen   = 3'd3,
    RegTransBlue    = 3'd4
  } reg_index_e;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [VecW:0]   mvec_t;

  // Per-ray values that ride along the square root pipeline.
  typedef struct packed {
    mvec_t             mx;
    mvec_t             my;
    mvec_t             mz;
    vec_t              vx;
    vec_t              vy;
    vec_t              vz;
    logic [RatioW-1:0] r;
    logic [ArW-1:0]    ar;
    logic              tir;
  } rdw_side_t;

  // Per-ray values that ride along the divider pipeline.
  typedef struct packed {
    vec_t lx;
    vec_t ly;
    vec_t lz;
    logic tir;
    logic graze;
  } rdw_dir_t;

endpackage

[rtl/rdw_front.sv]
module rdw_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [6*rdw_pkg::VecW-1:0] data_i,
  input  logic [rdw_pkg::RatioW-1:0] index_ratio_i,
  input  logic [rdw_pkg::RatioW-1:0] inverse_index_i,
  output logic                       valid_o,
  output logic [rdw_pkg::SqrtW-1:0]  disc_o,
  output rdw_pkg::rdw_side_t         side_o
);

  logic [5:0] vld_q;

  rdw_pkg::vec_t nx_a_q, ny_a_q, nz_a_q, vx_a_q, vy_a_q, vz_a_q;
  rdw_pkg::vec_t nx_b_q, ny_b_q, nz_b_q, vx_b_q, vy_b_q, vz_b_q;
  logic signed [17:0] px_b_q, py_b_q, pz_b_q;
  rdw_pkg::rdw_side_t side_c_q, side_d_q, side_e_q, side_f_q;
  rdw_pkg::rdw_side_t side_d_d, side_f_d;
  logic [16:0] a_c_q;
  logic [19:0] r2_d_q;
  logic [16:0] c2_d_q;
  logic signed [26:0] t_e_q;
  logic [rdw_pkg::SqrtW-1:0] disc_f_q;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Stage B: the three dot product terms, floored to Q3.14.
  logic signed [31:0] px, py, pz;
  always_comb begin
    px = nx_a_q * vx_a_q;
    py = ny_a_q * vy_a_q;
    pz = nz_a_q * vz_a_q;
  end

  // Stage C: saturated dot product, ratio select and normal flip.
  logic signed [19:0] dsum;
  rdw_pkg::vec_t      c;
  logic signed [16:0] ce;
  always_comb begin
    dsum = px_b_q + py_b_q + pz_b_q;
    if (dsum > 20'sd32767) begin
      c = 16'sh7fff;
    end else if (dsum < -20'sd32768) begin
      c = 16'sh8000;
    end else begin
      c = dsum[15:0];
    end
    ce = {c[15], c};
  end

  // Stage D: squares of the ratio and the cosine, and a times r.
  logic [31:0] rr;
  logic [33:0] aa;
  logic [32:0] arp;
  always_comb begin
    rr  = side_c_q.r * side_c_q.r;
    aa  = a_c_q * a_c_q;
    arp = a_c_q * side_c_q.r;
    side_d_d    = side_c_q;
    side_d_d.ar = arp[32:12];
  end

  // Stage E: (1 - a*a) * r*r.
  logic signed [17:0] s;
  logic signed [38:0] sr;
  always_comb begin
    s  = 18'sd16384 - $signed({1'b0, c2_d_q});
    sr = s * $signed({1'b0, r2_d_q});
  end

  // Stage F: discriminant, its sign and its clamp.
  logic signed [27:0] disc;
  always_comb begin
    disc = 28'sd16384 - {t_e_q[26], t_e_q};
    side_f_d     = side_e_q;
    side_f_d.tir = disc[27];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_a_q <= data_i[15:0];
      ny_a_q <= data_i[31:16];
      nz_a_q <= data_i[47:32];
      vx_a_q <= data_i[63:48];
      vy_a_q <= data_i[79:64];
      vz_a_q <= data_i[95:80];

      nx_b_q <= nx_a_q;
      ny_b_q <= ny_a_q;
      nz_b_q <= nz_a_q;
      vx_b_q <= vx_a_q;
      vy_b_q <= vy_a_q;
      vz_b_q <= vz_a_q;
      px_b_q <= px[31:14];
      py_b_q <= py[31:14];
      pz_b_q <= pz[31:14];

      side_c_q.mx  <= c[15] ? -{nx_b_q[15], nx_b_q} : {nx_b_q[15], nx_b_q};
      side_c_q.my  <= c[15] ? -{ny_b_q[15], ny_b_q} : {ny_b_q[15], ny_b_q};
      side_c_q.mz  <= c[15] ? -{nz_b_q[15], nz_b_q} : {nz_b_q[15], nz_b_q};
      side_c_q.vx  <= vx_b_q;
      side_c_q.vy  <= vy_b_q;
      side_c_q.vz  <= vz_b_q;
      side_c_q.r   <= (!c[15] && (c != '0)) ? inverse_index_i : index_ratio_i;
      side_c_q.ar  <= '0;
      side_c_q.tir <= 1'b0;
      a_c_q        <= c[15] ? 17'(-ce) : 17'(ce);

      side_d_q <= side_d_d;
      r2_d_q   <= rr[31:12];
      c2_d_q   <= aa[30:14];

      side_e_q <= side_d_q;
      t_e_q    <= sr[38:12];

      side_f_q <= side_f_d;
      disc_f_q <= (disc > 28'sd32767) ? 15'h7fff : disc[14:0];
    end
  end

  assign valid_o = vld_q[5];
  assign disc_o  = disc_f_q;
  assign side_o  = side_f_q;

endmodule

[rtl/rdw_sqrt.sv]
module rdw_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rdw_pkg::SqrtW-1:0] disc_i,
  input  rdw_pkg::rdw_side_t        side_i,
  output logic                      valid_o,
  output logic [rdw_pkg::SqrtW-1:0] root_o,
  output rdw_pkg::rdw_side_t        side_o
);

  localparam int N    = rdw_pkg::SqrtW;
  localparam int RemW = 2 * N;

  logic [N-1:0]              vld_q;
  logic [N-1:0]              root_q [N];
  logic [RemW-1:0]           rem_q  [N-1];
  rdw_pkg::rdw_side_t        side_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  // One root bit per stage, most significant first; rem holds x - root^2.
  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [RemW-1:0] rem_in, delta, rem_out;
    logic [N-1:0]    root_in;
    logic            take;
    rdw_pkg::rdw_side_t side_in;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, disc_i, {rdw_pkg::FracW{1'b0}}};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      delta   = ({{N{1'b0}}, root_in} << (N - j)) + (RemW'(1) << (2 * (N - 1 - j)));
      take    = (rem_in >= delta);
      rem_out = take ? (rem_in - delta) : rem_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j] <= root_in | (N'(take) << (N - 1 - j));
        side_q[j] <= side_in;
      end
    end

    if (j < N - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rem_out;
        end
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[rtl/rdw_dir.sv]
module rdw_dir (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [rdw_pkg::SqrtW-1:0] root_i,
  input  rdw_pkg::rdw_side_t        side_i,
  output logic                      valid_o,
  output rdw_pkg::rdw_dir_t         dir_o,
  output logic [rdw_pkg::DenW-1:0]  den_o
);

  logic [4:0] vld_q;

  rdw_pkg::rdw_side_t side_k_q, side_1_q;
  rdw_pkg::vec_t      k_q;
  logic signed [18:0] mkx_q, mky_q, mkz_q;
  logic signed [20:0] vrx_q, vry_q, vrz_q;
  rdw_pkg::mvec_t     mx_2_q, my_2_q, mz_2_q, mx_3_q, my_3_q, mz_3_q;
  rdw_pkg::vec_t      lx_2_q, ly_2_q, lz_2_q;
  rdw_pkg::rdw_dir_t  dir_3_q, dir_4_q, dir_4_d;
  logic               tir_2_q;
  logic signed [18:0] qx_q, qy_q, qz_q;
  logic [rdw_pkg::DenW-1:0] den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  function automatic rdw_pkg::vec_t sat_vec(input logic signed [21:0] x);
    rdw_pkg::vec_t res;
    if (x > 22'sd32767) begin
      res = 16'sh7fff;
    end else if (x < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

  // Scale factor k = a*r - sqrt(disc).
  logic signed [21:0] kd;
  always_comb begin
    kd = $signed({1'b0, side_i.ar}) - $signed({7'b0, root_i});
  end

  // Products m*k and v*r.
  logic signed [32:0] mkx, mky, mkz, vrx, vry, vrz;
  always_comb begin
    mkx = side_k_q.mx * k_q;
    mky = side_k_q.my * k_q;
    mkz = side_k_q.mz * k_q;
    vrx = side_k_q.vx * $signed({1'b0, side_k_q.r});
    vry = side_k_q.vy * $signed({1'b0, side_k_q.r});
    vrz = side_k_q.vz * $signed({1'b0, side_k_q.r});
  end

  // Terms of the exit cosine m.l.
  logic signed [32:0] qx, qy, qz;
  always_comb begin
    qx = mx_2_q * lx_2_q;
    qy = my_2_q * ly_2_q;
    qz = mz_2_q * lz_2_q;
  end

  // Exit cosine, grazing test and divisor.
  logic signed [20:0] qsum;
  logic signed [21:0] cost;
  logic               graze;
  always_comb begin
    qsum  = qx_q + qy_q + qz_q;
    cost  = -$signed({qsum[20], qsum});
    graze = (cost <= 22'(rdw_pkg::CosThr));
    dir_4_d       = dir_3_q;
    dir_4_d.graze = graze;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_k_q <= side_i;
      k_q      <= sat_vec(kd);

      side_1_q <= side_k_q;
      mkx_q    <= mkx[32:14];
      mky_q    <= mky[32:14];
      mkz_q    <= mkz[32:14];
      vrx_q    <= vrx[32:12];
      vry_q    <= vry[32:12];
      vrz_q    <= vrz[32:12];

      mx_2_q  <= side_1_q.mx;
      my_2_q  <= side_1_q.my;
      mz_2_q  <= side_1_q.mz;
      tir_2_q <= side_1_q.tir;
      lx_2_q  <= sat_vec(22'(mkx_q) - 22'(vrx_q));
      ly_2_q  <= sat_vec(22'(mky_q) - 22'(vry_q));
      lz_2_q  <= sat_vec(22'(mkz_q) - 22'(vrz_q));

      mx_3_q        <= mx_2_q;
      my_3_q        <= my_2_q;
      mz_3_q        <= mz_2_q;
      dir_3_q.lx    <= lx_2_q;
      dir_3_q.ly    <= ly_2_q;
      dir_3_q.lz    <= lz_2_q;
      dir_3_q.tir   <= tir_2_q;
      dir_3_q.graze <= 1'b0;
      qx_q          <= qx[32:14];
      qy_q          <= qy[32:14];
      qz_q          <= qz[32:14];

      dir_4_q <= dir_4_d;
      den_q   <= graze ? rdw_pkg::DenW'(1) : cost[rdw_pkg::DenW-1:0];
    end
  end

  assign valid_o = vld_q[4];
  assign dir_o   = dir_4_q;
  assign den_o   = den_q;

endmodule

[rtl/rdw_div.sv]
module rdw_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [rdw_pkg::NumW-1:0] num_i,
  input  logic [rdw_pkg::DenW-1:0] den_i,
  output logic [rdw_pkg::NumW-1:0] quo_o
);

  localparam int N = rdw_pkg::NumW;
  localparam int D = rdw_pkg::DenW;

  logic [N-1:0] quo_q [N];
  logic [D-1:0] rem_q [N-1];
  logic [N-1:0] num_q [N-1];
  logic [D-1:0] den_q [N-1];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [D-1:0] rem_in, den_in;
    logic [N-1:0] num_in, quo_in;
    logic [D:0]   rem_sh, rem_out;
    logic         take;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      rem_sh  = {rem_in, num_in[N-1-j]};
      take    = (rem_sh >= {1'b0, den_in});
      rem_out = take ? (rem_sh - {1'b0, den_in}) : rem_sh;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j] <= quo_in | (N'(take) << (N - 1 - j));
      end
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= rem_out[D-1:0];
          num_q[j] <= num_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

[rtl/refraction_direction_weight.sv]
// Snell refraction with transmittance weights, fully pipelined.
// Depth: 57 register stages from the input transfer to the output register.
// Throughput: one ray per cycle unless the output stalls; the square root (15 stages) and the three
// dividers (30 stages) each retire one bit per stage.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
module refraction_direction_weight (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input rays.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // normal_x, normal_y, normal_z, view_x, view_y, view_z
  input  logic [6*rdw_pkg::VecW-1:0]  s_axis_tdata,
  // Results.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // dir_x, dir_y, dir_z, weight_red, weight_green, weight_blue
  output logic [3*rdw_pkg::VecW+3*rdw_pkg::WeightW-1:0] m_axis_tdata,
  // transmitted
  output logic [0:0]                  m_axis_tuser,
  // Register writes.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rdw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);

  localparam int DivN = rdw_pkg::NumW;

  logic en;
  logic out_vld_q;

  logic [rdw_pkg::RatioW-1:0] index_ratio_q, inverse_index_q;
  logic [rdw_pkg::ColorW-1:0] trans_red_q, trans_green_q, trans_blue_q;

  // The whole pipeline advances unless a result waits on a stalled output.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_ratio_q   <= 16'd6144;
      inverse_index_q <= 16'd2731;
      trans_red_q     <= '1;
      trans_green_q   <= '1;
      trans_blue_q    <= '1;
    end else if (cfg_valid_i) begin
      case (rdw_pkg::reg_index_e'(cfg_index_i))
        rdw_pkg::RegIndexRatio:   index_ratio_q   <= cfg_data_i;
        rdw_pkg::RegInverseIndex: inverse_index_q <= cfg_data_i;
        rdw_pkg::RegTransRed:     trans_red_q     <= cfg_data_i;
        rdw_pkg::RegTransGreen:   trans_green_q   <= cfg_data_i;
        rdw_pkg::RegTransBlue:    trans_blue_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                      fr_vld, sq_vld, dr_vld;
  logic [rdw_pkg::SqrtW-1:0] fr_disc, sq_root;
  rdw_pkg::rdw_side_t        fr_side, sq_side;
  rdw_pkg::rdw_dir_t         dr_dir;
  logic [rdw_pkg::DenW-1:0]  dr_den;

  rdw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (s_axis_tvalid),
    .data_i          (s_axis_tdata),
    .index_ratio_i   (index_ratio_q),
    .inverse_index_i (inverse_index_q),
    .valid_o         (fr_vld),
    .disc_o          (fr_disc),
    .side_o          (fr_side)
  );

  rdw_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .disc_i  (fr_disc),
    .side_i  (fr_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  rdw_dir u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .root_i  (sq_root),
    .side_i  (sq_side),
    .valid_o (dr_vld),
    .dir_o   (dr_dir),
    .den_o   (dr_den)
  );

  // Transmittance over cosine, one divider per color.
  logic [DivN-1:0] quo_r, quo_g, quo_b;

  rdw_div u_div_red (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({trans_red_q, {(DivN - rdw_pkg::ColorW){1'b0}}}),
    .den_i (dr_den),
    .quo_o (quo_r)
  );

  rdw_div u_div_green (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({trans_green_q, {(DivN - rdw_pkg::ColorW){1'b0}}}),
    .den_i (dr_den),
    .quo_o (quo_g)
  );

  rdw_div u_div_blue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({trans_blue_q, {(DivN - rdw_pkg::ColorW){1'b0}}}),
    .den_i (dr_den),
    .quo_o (quo_b)
  );

  // Direction and flags wait alongside the dividers.
  logic [DivN-1:0]   dly_vld_q;
  rdw_pkg::rdw_dir_t dly_dir_q [DivN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
    end else if (en) begin
      dly_vld_q <= {dly_vld_q[DivN-2:0], dr_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_dir_q[0] <= dr_dir;
      for (int i = 1; i < DivN; i++) begin
        dly_dir_q[i] <= dly_dir_q[i-1];
      end
    end
  end

  function automatic logic [rdw_pkg::WeightW-1:0] sat_w(input logic [DivN-1:0] q);
    logic [rdw_pkg::WeightW-1:0] res;
    if (q > DivN'({rdw_pkg::WeightW{1'b1}})) begin
      res = '1;
    end else begin
      res = q[rdw_pkg::WeightW-1:0];
    end
    return res;
  endfunction

  // Output register: zero on total internal reflection, zero weights when grazing.
  rdw_pkg::rdw_dir_t dend;
  logic [rdw_pkg::WeightW-1:0] wr, wg, wb;
  always_comb begin
    dend = dly_dir_q[DivN-1];
    wr   = dend.graze ? '0 : sat_w(quo_r);
    wg   = dend.graze ? '0 : sat_w(quo_g);
    wb   = dend.graze ? '0 : sat_w(quo_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dly_vld_q[DivN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dend.tir) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b0;
      end else begin
        m_axis_tdata <= {wb, wg, wr, dend.lz, dend.ly, dend.lx};
        m_axis_tuser <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;

`ifndef ASSERT_OFF
  // A reflected ray carries no direction and no weights.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("reflected result with nonzero data");

  // Input is taken exactly when the output side can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready disagrees with output stall");

  // A new result appears only after the pipeline advanced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared while stalled");
`endif

endmodule

[tb/testbench.sv]
module testbench;

  localparam int Frac = rdw_pkg::FracW;
  localparam longint OneQ = 64'sd1 <<< Frac;
  localparam longint VMax = (64'sd1 <<< (rdw_pkg::VecW - 1)) - 1;
  localparam longint VMin = -(64'sd1 <<< (rdw_pkg::VecW - 1));
  localparam longint WMax = 64'hFFFFFF;
  localparam int RandomRays = 400;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 80;

  // One ray and one result as the block sees them.
  typedef struct packed {
    rdw_pkg::vec_t vz, vy, vx, nz, ny, nx;
  } ray_t;

  typedef struct {
    longint dx, dy, dz, wr, wg, wb;
    bit     tx;
  } refr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [6*rdw_pkg::VecW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*rdw_pkg::VecW+3*rdw_pkg::WeightW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rdw_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  refraction_direction_weight dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the register file.
  longint ratio_q = 6144, inv_q = 2731;
  longint trans_q [3] = '{65535, 65535, 65535};

  refr_t expected_q [$];
  int fail_count = 0;
  int ray_count = 0;
  int result_count = 0;
  int tir_count = 0;
  int graze_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint color_weight(longint trans, longint cost);
    longint w;
    w = (trans <<< (Frac + 16 - rdw_pkg::ColorW)) / cost;
    return w > WMax ? WMax : w;
  endfunction

  // Computes the refracted direction and colour weights of one ray.
  function automatic refr_t refract(ray_t ray);
    longint n [3], v [3], m [3], l [3];
    longint c, a, r, r2, s, disc, sq, k, cost;
    refr_t res;
    n[0] = ray.nx; n[1] = ray.ny; n[2] = ray.nz;
    v[0] = ray.vx; v[1] = ray.vy; v[2] = ray.vz;
    res = '{default: 0};
    c = 0;
    for (int i = 0; i < 3; i++) c += floor_shr(n[i] * v[i], Frac);
    c = clamp(c, VMin, VMax);
    r = c > 0 ? inv_q : ratio_q;
    for (int i = 0; i < 3; i++) m[i] = c < 0 ? -n[i] : n[i];
    a = c < 0 ? -c : c;
    r2 = (r * r) >>> 12;
    s = OneQ - floor_shr(a * a, Frac);
    disc = OneQ - floor_shr(s * r2, 12);
    if (disc < 0) return res;
    disc = clamp(disc, 0, VMax);
    sq = int_sqrt(disc <<< Frac);
    k = clamp(floor_shr(a * r, 12) - sq, VMin, VMax);
    for (int i = 0; i < 3; i++)
      l[i] = clamp(floor_shr(m[i] * k, Frac) - floor_shr(v[i] * r, 12), VMin, VMax);
    res.dx = l[0]; res.dy = l[1]; res.dz = l[2];
    res.tx = 1'b1;
    cost = 0;
    for (int i = 0; i < 3; i++) cost += floor_shr(m[i] * l[i], Frac);
    cost = -cost;
    if (cost > rdw_pkg::CosThr) begin
      res.wr = color_weight(trans_q[0], cost);
      res.wg = color_weight(trans_q[1], cost);
      res.wb = color_weight(trans_q[2], cost);
    end
    return res;
  endfunction

  // Holds valid high after the transfer; the caller drops it when writes end.
  task automatic write_reg(input rdw_pkg::reg_index_e idx, input logic [15:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    case (idx)
      rdw_pkg::RegIndexRatio:   ratio_q = value;
      rdw_pkg::RegInverseIndex: inv_q = value;
      rdw_pkg::RegTransRed:     trans_q[0] = value;
      rdw_pkg::RegTransGreen:   trans_q[1] = value;
      rdw_pkg::RegTransBlue:    trans_q[2] = value;
      default: ;
    endcase
  endtask

  // Sends one ray; a typed-in expectation replaces the predicted one when given.
  // Valid is dropped only for an idle gap, so back-to-back rays keep it high.
  task automatic send_ray(input ray_t ray, input bit use_typed, input refr_t typed,
                          input bit may_gap);
    refr_t exp_res;
    int gap;
    gap = (may_gap && $urandom_range(3, 0) != 0) ? $urandom_range(18, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    exp_res = use_typed ? typed : refract(ray);
    s_axis_tdata  <= ray;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(exp_res);
    ray_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Result checker on the output side.
  always @(posedge clk_i) begin
    refr_t want;
    rdw_pkg::vec_t gx, gy, gz;
    logic [rdw_pkg::WeightW-1:0] gr, gg, gb;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      {gb, gg, gr, gz, gy, gx} = m_axis_tdata;
      result_count++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (!want.tx) tir_count++;
        else if (want.wr == 0 && want.wg == 0 && want.wb == 0) graze_count++;
        if (longint'(gx) != want.dx) begin
          $error("dir_x expected %0d actual %0d", want.dx, gx); fail_count++;
        end
        if (longint'(gy) != want.dy) begin
          $error("dir_y expected %0d actual %0d", want.dy, gy); fail_count++;
        end
        if (longint'(gz) != want.dz) begin
          $error("dir_z expected %0d actual %0d", want.dz, gz); fail_count++;
        end
        if (longint'(gr) != want.wr) begin
          $error("weight_red expected %0d actual %0d", want.wr, gr); fail_count++;
        end
        if (longint'(gg) != want.wg) begin
          $error("weight_green expected %0d actual %0d", want.wg, gg); fail_count++;
        end
        if (longint'(gb) != want.wb) begin
          $error("weight_blue expected %0d actual %0d", want.wb, gb); fail_count++;
        end
        if (m_axis_tuser[0] != want.tx) begin
          $error("transmitted expected %0d actual %0d", want.tx, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure: a random stall before each result, some stretches none.
  initial begin
    int gap;
    bit calm;
    forever begin
      @(negedge clk_i);
      calm = ($urandom_range(7, 0) == 0);
      gap = calm ? 0 : $urandom_range(18, 0);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o) || stim_done && expected_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic rdw_pkg::vec_t rand_comp();
    return rdw_pkg::vec_t'($urandom_range(32767, 0) - 16384);
  endfunction

  // Random ray: mostly near-unit vectors, some raw 16-bit noise.
  function automatic ray_t rand_ray();
    ray_t ray;
    if ($urandom_range(4, 0) == 0) begin
      ray = {$urandom(), $urandom(), $urandom()};
    end else begin
      ray.nx = rand_comp(); ray.ny = rand_comp(); ray.nz = rand_comp();
      ray.vx = rand_comp(); ray.vy = rand_comp(); ray.vz = rand_comp();
      // Put most of the length on one axis to stay close to unit size.
      case ($urandom_range(2, 0))
        0: ray.nx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: ray.ny = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: ray.nz = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end
    return ray;
  endfunction

  localparam rdw_pkg::vec_t P1 = 16'sd16384;
  localparam rdw_pkg::vec_t N1 = -16'sd16384;
  localparam rdw_pkg::vec_t Z0 = 16'sd0;
  localparam rdw_pkg::vec_t SMax = 16'sh7FFF;
  localparam rdw_pkg::vec_t SMin = -16'sh8000;

  typedef struct {
    ray_t  ray;
    bit    typed;
    refr_t want;
  } stim_row_t;

  // Directed rays: head-on both sides, zero dot, grazing, total internal
  // reflection, field extremes.
  stim_row_t directed [12] = '{
    '{'{P1, Z0, Z0, N1, Z0, Z0}, 0, '{default: 0}},
    '{'{N1, Z0, Z0, N1, Z0, Z0}, 0, '{default: 0}},
    '{'{Z0, Z0, Z0, Z0, Z0, Z0}, 0, '{default: 0}},
    '{'{Z0, Z0, P1, Z0, P1, Z0}, 0, '{default: 0}},
    '{'{16'sd1000, Z0, P1, Z0, 16'sd15000, Z0}, 0, '{default: 0}},
    '{'{Z0, 16'sd15900, 16'sd4000, Z0, Z0, P1}, 0, '{default: 0}},
    '{'{SMax, SMax, SMax, SMax, SMax, SMax}, 0, '{default: 0}},
    '{'{SMin, SMin, SMin, SMin, SMin, SMin}, 0, '{default: 0}},
    '{'{SMax, SMin, SMax, SMin, SMax, SMin}, 0, '{default: 0}},
    '{'{SMin, SMax, SMin, SMax, SMin, SMax}, 0, '{default: 0}},
    '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 0,
      '{default: 0}},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 0, '{default: 0}}
  };

  initial begin
    refr_t none;
    none = '{default: 0};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings; a glancing ray from the dense side reflects totally.
    send_ray('{Z0, 16'sd16000, -16'sd3000, Z0, Z0, P1}, 1, none, 0);
    foreach (directed[i]) send_ray(directed[i].ray, directed[i].typed, directed[i].want, 1);
    wait_idle();

    // Register extremes, then random settings between random phases.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(rdw_pkg::RegIndexRatio, 16'd0);
          write_reg(rdw_pkg::RegInverseIndex, 16'd0);
          write_reg(rdw_pkg::RegTransRed, 16'd0);
          write_reg(rdw_pkg::RegTransGreen, 16'hFFFF);
          write_reg(rdw_pkg::RegTransBlue, 16'd1);
        end
        1: begin
          write_reg(rdw_pkg::RegIndexRatio, 16'hFFFF);
          write_reg(rdw_pkg::RegInverseIndex, 16'hFFFF);
          write_reg(rdw_pkg::RegTransRed, 16'hFFFF);
          write_reg(rdw_pkg::RegTransGreen, 16'd0);
          write_reg(rdw_pkg::RegTransBlue, 16'hFFFF);
        end
        2: begin
          write_reg(rdw_pkg::RegIndexRatio, 16'd4096);
          write_reg(rdw_pkg::RegInverseIndex, 16'd4096);
        end
        3: begin
          write_reg(rdw_pkg::RegIndexRatio, 16'd1);
          write_reg(rdw_pkg::RegInverseIndex, 16'd1);
        end
        default: begin
          write_reg(rdw_pkg::RegIndexRatio, 16'($urandom_range(8192, 2048)));
          write_reg(rdw_pkg::RegInverseIndex, 16'($urandom_range(8192, 2048)));
          write_reg(rdw_pkg::RegTransRed, 16'($urandom()));
          write_reg(rdw_pkg::RegTransGreen, 16'($urandom()));
          write_reg(rdw_pkg::RegTransBlue, 16'($urandom()));
        end
      endcase
      cfg_valid_i <= 1'b0;
      if (phase < 2) foreach (directed[i]) send_ray(directed[i].ray, 0, none, 1);
      repeat (RandomRays / 8) send_ray(rand_ray(), 0, none, 1);
      wait_idle();
    end

    stim_done = 1'b1;
    $display("Sent %0d rays over several register settings; %0d results checked.",
             ray_count, result_count);
    $display("Total internal reflections: %0d, grazing exits: %0d.",
             tir_count, graze_count);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
